// File: hdl/ubxp_pkg.sv
`default_nettype none

package ubxp_pkg;

  localparam logic [7:0]  SYNC_CHAR_1     = 8'hB5;
  localparam logic [7:0]  SYNC_CHAR_2     = 8'h62;
  localparam logic [7:0]  CLASS_NAV       = 8'h01;
  localparam logic [7:0]  ID_NAV_PVT      = 8'h07;
  localparam logic [15:0] LEN_NAV_PVT     = 16'd92;
  localparam logic [7:0]  CLASS_ACK       = 8'h05;
  localparam logic [7:0]  ID_ACK_ACK      = 8'h01;
  localparam logic [7:0]  ID_ACK_NAK      = 8'h00;
  localparam logic [15:0] MAX_LEN_RESET   = 16'd512;

  // result queue between parser and output stage
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LENL,
    PH_PAYLOAD,
    PH_CHKA,
    PH_CHKB
  } phase_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } out_kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHKA_BAD = 2'd1,
    ST_CHKB_BAD = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MK_OTHER   = 2'd0,
    MK_NAV_PVT = 2'd1,
    MK_ACK     = 2'd2,
    MK_NACK    = 2'd3
  } msg_kind_t;

  // one parsed result word, before message classification
  typedef struct packed {
    out_kind_t   kind;
    logic [7:0]  data;
    logic [15:0] idx;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    status_t     status;
  } rec_t;

  typedef struct packed {
    logic                full;
    logic                empty;
    logic [QUEUE_CW-1:0] count;
  } queue_stat_t;

endpackage

`default_nettype wire

// File: hdl/ubx_frame_parser.sv
// UBX frame parser: one received byte per in_ word, one byte per clock while the
// result queue is not full. The parser walks sync, class, id, length, payload and
// the two Fletcher-8 check bytes and pushes any result into a 4-word queue; an
// output register drains that queue. in_tready falls only while the queue is full
// (output side stalled), so throughput is limited by the output consumer alone.
// Every payload byte yields a payload word (out_tuser 0); frame end, a bad check
// byte or an over-length header yields a frame-end word (out_tuser 1).
// max_payload_len is written via cfg_ and resets to 512; write it only while no
// frame is in flight.
`default_nettype none

module ubx_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] data_byte, [23:8] byte_index, [31:24] frame_class, [39:32] frame_id,
  // [55:40] frame_length, [57:56] frame_status, [59:58] message_kind, [63:60] zero
  output logic [63:0]      out_tdata,
  output logic             out_tuser,  // [0] out_kind
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data    // max_payload_len
);

  ubxp_pkg::rec_t        push_rec;
  ubxp_pkg::rec_t        head_rec;
  ubxp_pkg::queue_stat_t q_stat;
  logic                  push;
  logic                  pop;
  logic                  in_accept;

  assign in_tready = !q_stat.full;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  ubxp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .rx_byte  (in_tdata),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .rec      (push_rec),
    .push     (push)
  );

  ubxp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_rec (push_rec),
    .pop    (pop),
    .rd_rec (head_rec),
    .stat   (q_stat)
  );

  ubxp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec        (head_rec),
    .rec_avail  (!q_stat.empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= ubxp_pkg::QUEUE_CW'(ubxp_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop && !q_stat.full) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
    else $error("queue count lost a word");

  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[59:56] == 4'd0))
    else $error("payload word carries status or message kind");

  a_payload_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[23:8] < out_tdata[55:40]))
    else $error("payload index beyond frame length");
`endif

endmodule

`default_nettype wire

// File: hdl/ubxp_front.sv
`default_nettype none

module ubxp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_data,
  output ubxp_pkg::rec_t     rec,
  output logic               push
);

  ubxp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  cls_r, cls_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] max_len_r, max_len_nxt;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] len_full;
  logic [16:0] cnt_inc;
  logic        too_long;

  assign add_a    = sum_a_r + rx_byte;
  assign add_b    = sum_b_r + add_a;
  assign len_full = {rx_byte, len_r[7:0]};
  assign cnt_inc  = {1'b0, cnt_r} + 17'd1;
  assign too_long = len_full > max_len_r;

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    sum_a_nxt   = sum_a_r;
    sum_b_nxt   = sum_b_r;
    cls_nxt     = cls_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    max_len_nxt = cfg_we ? cfg_data : max_len_r;
    if (accept) begin
      case (phase_r)
        ubxp_pkg::PH_SYNC1: begin
          if (rx_byte == ubxp_pkg::SYNC_CHAR_2) begin
            phase_nxt = ubxp_pkg::PH_SYNC2;
            sum_a_nxt = 8'd0;
            sum_b_nxt = 8'd0;
          end else begin
            phase_nxt = ubxp_pkg::PH_IDLE;
          end
        end
        ubxp_pkg::PH_SYNC2: begin
          cls_nxt   = rx_byte;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = ubxp_pkg::PH_CLASS;
        end
        ubxp_pkg::PH_CLASS: begin
          id_nxt    = rx_byte;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = ubxp_pkg::PH_ID;
        end
        ubxp_pkg::PH_ID: begin
          len_nxt   = {8'd0, rx_byte};
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = ubxp_pkg::PH_LENL;
        end
        ubxp_pkg::PH_LENL: begin
          len_nxt   = len_full;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          cnt_nxt   = 16'd0;
          if (too_long) begin
            phase_nxt = ubxp_pkg::PH_IDLE;
          end else if (len_full == 16'd0) begin
            phase_nxt = ubxp_pkg::PH_CHKA;
          end else begin
            phase_nxt = ubxp_pkg::PH_PAYLOAD;
          end
        end
        ubxp_pkg::PH_PAYLOAD: begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          cnt_nxt   = cnt_inc[15:0];
          if (cnt_inc >= {1'b0, len_r}) begin
            phase_nxt = ubxp_pkg::PH_CHKA;
          end
        end
        ubxp_pkg::PH_CHKA: begin
          phase_nxt = (rx_byte == sum_a_r) ? ubxp_pkg::PH_CHKB : ubxp_pkg::PH_IDLE;
        end
        ubxp_pkg::PH_CHKB: begin
          phase_nxt = ubxp_pkg::PH_IDLE;
        end
        default: begin
          phase_nxt = (rx_byte == ubxp_pkg::SYNC_CHAR_1) ? ubxp_pkg::PH_SYNC1
                                                         : ubxp_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // result word for the queue
  always_comb begin
    push       = 1'b0;
    rec.kind   = ubxp_pkg::KIND_PAYLOAD;
    rec.data   = rx_byte;
    rec.idx    = cnt_r;
    rec.cls    = cls_r;
    rec.id     = id_r;
    rec.len    = len_r;
    rec.status = ubxp_pkg::ST_OK;
    if (accept) begin
      case (phase_r)
        ubxp_pkg::PH_LENL: begin
          rec.len = len_full;
          if (too_long) begin
            push       = 1'b1;
            rec.kind   = ubxp_pkg::KIND_END;
            rec.data   = 8'd0;
            rec.idx    = 16'd0;
            rec.status = ubxp_pkg::ST_TOO_LONG;
          end
        end
        ubxp_pkg::PH_PAYLOAD: begin
          push = 1'b1;
        end
        ubxp_pkg::PH_CHKA: begin
          if (rx_byte != sum_a_r) begin
            push       = 1'b1;
            rec.kind   = ubxp_pkg::KIND_END;
            rec.data   = 8'd0;
            rec.idx    = 16'd0;
            rec.status = ubxp_pkg::ST_CHKA_BAD;
          end
        end
        ubxp_pkg::PH_CHKB: begin
          push       = 1'b1;
          rec.kind   = ubxp_pkg::KIND_END;
          rec.data   = 8'd0;
          rec.idx    = 16'd0;
          rec.status = (rx_byte == sum_b_r) ? ubxp_pkg::ST_OK : ubxp_pkg::ST_CHKB_BAD;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ubxp_pkg::PH_IDLE;
      sum_a_r   <= 8'd0;
      sum_b_r   <= 8'd0;
      cls_r     <= 8'd0;
      id_r      <= 8'd0;
      len_r     <= 16'd0;
      cnt_r     <= 16'd0;
      max_len_r <= ubxp_pkg::MAX_LEN_RESET;
    end else begin
      phase_r   <= phase_nxt;
      sum_a_r   <= sum_a_nxt;
      sum_b_r   <= sum_b_nxt;
      cls_r     <= cls_nxt;
      id_r      <= id_nxt;
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      max_len_r <= max_len_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ubxp_queue.sv
`default_nettype none

module ubxp_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire ubxp_pkg::rec_t      wr_rec,
  input  wire logic                pop,
  output ubxp_pkg::rec_t           rd_rec,
  output ubxp_pkg::queue_stat_t    stat
);

  ubxp_pkg::rec_t slot_r [ubxp_pkg::QUEUE_DEPTH];

  logic [ubxp_pkg::QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ubxp_pkg::QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ubxp_pkg::QUEUE_CW-1:0] count_r, count_nxt;

  logic do_push;
  logic do_pop;

  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == ubxp_pkg::QUEUE_CW'(ubxp_pkg::QUEUE_DEPTH));

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;
  assign rd_rec  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ubxp_back.sv
`default_nettype none

module ubxp_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ubxp_pkg::rec_t  rec,
  input  wire logic            rec_avail,
  output logic                 pop,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [63:0]          out_tdata,
  output logic                 out_tuser
);

  logic        valid_r, valid_nxt;
  logic [63:0] data_r, data_nxt;
  logic        user_r, user_nxt;

  ubxp_pkg::msg_kind_t mkind;

  always_comb begin
    mkind = ubxp_pkg::MK_OTHER;
    if (rec.kind == ubxp_pkg::KIND_END) begin
      if (rec.cls == ubxp_pkg::CLASS_NAV && rec.id == ubxp_pkg::ID_NAV_PVT &&
          rec.len == ubxp_pkg::LEN_NAV_PVT) begin
        mkind = ubxp_pkg::MK_NAV_PVT;
      end else if (rec.cls == ubxp_pkg::CLASS_ACK && rec.id == ubxp_pkg::ID_ACK_ACK) begin
        mkind = ubxp_pkg::MK_ACK;
      end else if (rec.cls == ubxp_pkg::CLASS_ACK && rec.id == ubxp_pkg::ID_ACK_NAK) begin
        mkind = ubxp_pkg::MK_NACK;
      end
    end
  end

  // load a new word whenever the output register is free or being drained
  assign pop = rec_avail && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    user_nxt  = user_r;
    if (pop) begin
      valid_nxt = 1'b1;
      data_nxt  = {4'd0, mkind, rec.status, rec.len, rec.id, rec.cls, rec.idx, rec.data};
      user_nxt  = rec.kind;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    user_r <= user_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

`default_nettype wire
